[design/u8v_pkg.sv]
package u8v_pkg;

   // Verdict codes, in the order of their priority after the ok code.
   typedef enum logic [1:0] {
      VERDICT_OK       = 2'd0,
      VERDICT_TOO_LARGE = 2'd1,
      VERDICT_BAD_UTF8 = 2'd2,
      VERDICT_NUL      = 2'd3
   } verdict_type;

   localparam int unsigned LENGTH_W = 32;
   localparam int unsigned CP_W     = 21;

   localparam logic [LENGTH_W-1:0] MAX_LENGTH_RESET = '1;
   localparam logic [LENGTH_W-1:0] COUNT_SATURATED  = '1;

   // Code point limits for the overlong, surrogate and range checks.
   localparam logic [CP_W-1:0] CP_MIN_THREE    = 21'h000800;
   localparam logic [CP_W-1:0] CP_MIN_FOUR     = 21'h010000;
   localparam logic [CP_W-1:0] CP_MAX          = 21'h10FFFF;
   localparam logic [CP_W-1:0] CP_SURROGATE_LO = 21'h00D800;
   localparam logic [CP_W-1:0] CP_SURROGATE_HI = 21'h00DFFF;

   // Continuation counts of the sequence kinds.
   localparam logic [1:0] EXTRA_NONE  = 2'd0;
   localparam logic [1:0] EXTRA_TWO   = 2'd1;
   localparam logic [1:0] EXTRA_THREE = 2'd2;
   localparam logic [1:0] EXTRA_FOUR  = 2'd3;

endpackage

[design/u8v_ifs.sv]
// Text byte channel.
interface u8v_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

// Verdict channel.
interface u8v_verdict_if;
   import u8v_pkg::*;

   logic        valid;
   logic        ready;
   verdict_type verdict;

   modport source (output valid, output verdict, input ready);
   modport sink (input valid, input verdict, output ready);
endinterface

// Register write channel for max_length.
interface u8v_csr_if;
   import u8v_pkg::*;

   logic                valid;
   logic                ready;
   logic [LENGTH_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[design/text_utf8_validator.sv]
// Channel | Direction | Beat contents
// req     | in        | text_byte (8), final_byte (1)
// rsp     | out       | verdict (2), one beat per text, after its final byte
// csr     | in        | data (32): max_length, always ready
//
// One byte is taken per cycle; a stalled verdict holds req.ready low only while
// it is still waiting. The verdict of a text appears in the cycle after its
// final byte. The per-byte checks sit between the state registers and the
// verdict register. Reset is synchronous and sets max_length to all ones.
module text_utf8_validator (
   input  logic                 clock,
   input  logic                 reset,
   u8v_byte_if.sink             req,
   u8v_verdict_if.source        rsp,
   u8v_csr_if.sink              csr
);
   import u8v_pkg::*;

   logic [LENGTH_W-1:0] max_length_ff;
   logic [1:0]          pending_ff, pending_in;
   logic [1:0]          seq_len_ff, seq_len_in;
   logic [CP_W-1:0]     code_point_ff, code_point_in;
   logic [LENGTH_W-1:0] bytes_seen_ff, bytes_seen_in;
   logic                bad_ff, bad_in;
   logic                nul_ff, nul_in;
   logic                too_long_ff, too_long_in;
   logic                rsp_valid_ff, rsp_valid_in;
   verdict_type         verdict_ff, verdict_in;

   logic                req_take;
   logic [7:0]          b;
   logic [CP_W-1:0]     cp_next;
   logic                cp_bad;

   assign b        = req.text_byte;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_take = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.verdict = verdict_ff;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr.valid) begin
         max_length_ff <= csr.data;
      end
   end

   // Code point after a continuation byte, and its range checks when complete.
   always_comb begin
      cp_next = {code_point_ff[CP_W-7:0], b[5:0]};
      cp_bad  = 1'b0;
      if (seq_len_ff == EXTRA_THREE && cp_next < CP_MIN_THREE) begin
         cp_bad = 1'b1;
      end
      if (seq_len_ff == EXTRA_FOUR && cp_next < CP_MIN_FOUR) begin
         cp_bad = 1'b1;
      end
      if (cp_next > CP_MAX) begin
         cp_bad = 1'b1;
      end
      if (cp_next >= CP_SURROGATE_LO && cp_next <= CP_SURROGATE_HI) begin
         cp_bad = 1'b1;
      end
   end

   // Per-byte update of the text state and the verdict register.
   always_comb begin
      pending_in    = pending_ff;
      seq_len_in    = seq_len_ff;
      code_point_in = code_point_ff;
      bytes_seen_in = bytes_seen_ff;
      bad_in        = bad_ff;
      nul_in        = nul_ff;
      too_long_in   = too_long_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      verdict_in    = verdict_ff;

      if (req_take) begin
         // The byte whose count passes max_length sets the flag.
         if (bytes_seen_ff >= max_length_ff) begin
            too_long_in = 1'b1;
         end
         if (bytes_seen_ff != COUNT_SATURATED) begin
            bytes_seen_in = bytes_seen_ff + 1'b1;
         end
         if (b == 8'h00) begin
            nul_in = 1'b1;
         end

         // Sequence tracking stops once the text is known to be malformed.
         if (!bad_ff) begin
            if (pending_ff == EXTRA_NONE) begin
               if (b[7]) begin
                  if (b[7:5] == 3'b110) begin
                     if (b[4:1] == 4'b0000) begin
                        bad_in = 1'b1;
                     end else begin
                        pending_in    = EXTRA_TWO;
                        seq_len_in    = EXTRA_TWO;
                        code_point_in = {{(CP_W-5){1'b0}}, b[4:0]};
                     end
                  end else if (b[7:4] == 4'b1110) begin
                     pending_in    = EXTRA_THREE;
                     seq_len_in    = EXTRA_THREE;
                     code_point_in = {{(CP_W-4){1'b0}}, b[3:0]};
                  end else if (b[7:3] == 5'b11110) begin
                     pending_in    = EXTRA_FOUR;
                     seq_len_in    = EXTRA_FOUR;
                     code_point_in = {{(CP_W-3){1'b0}}, b[2:0]};
                  end else begin
                     bad_in = 1'b1;
                  end
               end
            end else if (b[7:6] != 2'b10) begin
               bad_in     = 1'b1;
               pending_in = EXTRA_NONE;
            end else begin
               pending_in    = pending_ff - 1'b1;
               code_point_in = cp_next;
               if (pending_ff == EXTRA_TWO) begin
                  if (cp_bad) begin
                     bad_in = 1'b1;
                  end
                  code_point_in = '0;
                  seq_len_in    = EXTRA_NONE;
               end
            end
         end

         // Final byte: give the verdict and clear the text state.
         if (req.final_byte) begin
            rsp_valid_in = 1'b1;
            if (too_long_in) begin
               verdict_in = VERDICT_TOO_LARGE;
            end else if (bad_in || pending_in != EXTRA_NONE) begin
               verdict_in = VERDICT_BAD_UTF8;
            end else if (nul_in) begin
               verdict_in = VERDICT_NUL;
            end else begin
               verdict_in = VERDICT_OK;
            end
            pending_in    = EXTRA_NONE;
            seq_len_in    = EXTRA_NONE;
            code_point_in = '0;
            bytes_seen_in = '0;
            bad_in        = 1'b0;
            nul_in        = 1'b0;
            too_long_in   = 1'b0;
         end
      end
   end

   // Text state and verdict registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= EXTRA_NONE;
         seq_len_ff    <= EXTRA_NONE;
         code_point_ff <= '0;
         bytes_seen_ff <= '0;
         bad_ff        <= 1'b0;
         nul_ff        <= 1'b0;
         too_long_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pending_ff    <= pending_in;
         seq_len_ff    <= seq_len_in;
         code_point_ff <= code_point_in;
         bytes_seen_ff <= bytes_seen_in;
         bad_ff        <= bad_in;
         nul_ff        <= nul_in;
         too_long_ff   <= too_long_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   // A final beat always produces a verdict beat in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.final_byte |=> rsp.valid)
      else $error("final beat without verdict");

   // A final beat leaves the text state cleared.
   assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.final_byte |=>
         bytes_seen_ff == '0 && pending_ff == EXTRA_NONE && !bad_ff)
      else $error("text state not cleared after final beat");

   // Continuations still expected never exceed those of the open sequence.
   assert property (@(posedge clock) disable iff (reset)
      pending_ff <= seq_len_ff)
      else $error("pending count beyond sequence length");

   // A non-final beat never raises a verdict on its own.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !(req.valid && req.ready && req.final_byte) |=> !rsp.valid)
      else $error("verdict without final beat");

endmodule

[tb/sv/u8v_verdict_checker.sv]
// Watches the byte, verdict and register channels of the UTF-8 validator.
// Every accepted byte beat runs through a local copy of the validator state,
// every final byte queues the verdict that the text should get, and every
// verdict beat is compared with the oldest queued verdict.
module u8v_verdict_checker (
   input  logic        clock,
   input  logic        reset,
   u8v_byte_if         req,
   u8v_verdict_if      rsp,
   u8v_csr_if          csr,
   output int unsigned errors,
   output int unsigned awaited
);
   import u8v_pkg::*;

   // Local copy of the register and of the per-text state.
   logic [LENGTH_W-1:0] limit_reg;
   logic [LENGTH_W-1:0] byte_count;
   logic [1:0]          cont_left;
   logic [1:0]          cont_total;
   logic [CP_W-1:0]     code_acc;
   logic                bad_utf8;
   logic                saw_nul;
   logic                over_limit;

   verdict_type expected_verdicts[$];
   int unsigned fail_count = 0;
   int unsigned verdicts_due = 0;

   assign errors  = fail_count;
   assign awaited = verdicts_due;

   // One line per mismatch, and the count goes up by one.
   task automatic report(input string what);
      fail_count++;
      $display("tb check at %0t: %s", $realtime, what);
   endtask

   task automatic clear_text();
      byte_count = '0;
      cont_left  = EXTRA_NONE;
      cont_total = EXTRA_NONE;
      code_acc   = '0;
      bad_utf8   = 1'b0;
      saw_nul    = 1'b0;
      over_limit = 1'b0;
   endtask

   // Lead byte: either a single byte, the start of a sequence or malformed.
   task automatic take_lead(input logic [7:0] b);
      if (b[7]) begin
         if (b[7:5] == 3'b110) begin
            // Leads C0 and C1 can only encode overlong forms.
            if (b[4:1] == 4'd0) begin
               bad_utf8 = 1'b1;
            end else begin
               cont_left  = EXTRA_TWO;
               cont_total = EXTRA_TWO;
               code_acc   = CP_W'(b[4:0]);
            end
         end else if (b[7:4] == 4'b1110) begin
            cont_left  = EXTRA_THREE;
            cont_total = EXTRA_THREE;
            code_acc   = CP_W'(b[3:0]);
         end else if (b[7:3] == 5'b11110) begin
            cont_left  = EXTRA_FOUR;
            cont_total = EXTRA_FOUR;
            code_acc   = CP_W'(b[2:0]);
         end else begin
            // A stray continuation byte or one of F8..FF.
            bad_utf8 = 1'b1;
         end
      end
   endtask

   // Continuation position: gather six bits, check the code point when complete.
   task automatic take_continuation(input logic [7:0] b);
      if (b[7:6] != 2'b10) begin
         bad_utf8  = 1'b1;
         cont_left = EXTRA_NONE;
      end else begin
         code_acc  = {code_acc[CP_W-7:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == EXTRA_NONE) begin
            if (cont_total == EXTRA_THREE && code_acc < CP_MIN_THREE) begin
               bad_utf8 = 1'b1;
            end
            if (cont_total == EXTRA_FOUR && code_acc < CP_MIN_FOUR) begin
               bad_utf8 = 1'b1;
            end
            if (code_acc > CP_MAX) begin
               bad_utf8 = 1'b1;
            end
            if (code_acc >= CP_SURROGATE_LO && code_acc <= CP_SURROGATE_HI) begin
               bad_utf8 = 1'b1;
            end
            code_acc   = '0;
            cont_total = EXTRA_NONE;
         end
      end
   endtask

   // Advances the text state by one byte and queues a verdict on the final one.
   task automatic predict_byte(input logic [7:0] b, input logic last);
      verdict_type want;
      if (({1'b0, byte_count} + 33'd1) > {1'b0, limit_reg}) begin
         over_limit = 1'b1;
      end
      if (byte_count != COUNT_SATURATED) begin
         byte_count = byte_count + 1'b1;
      end
      if (b == 8'h00) begin
         saw_nul = 1'b1;
      end
      // Once the encoding is broken the sequence state is frozen.
      if (!bad_utf8) begin
         if (cont_left == EXTRA_NONE) begin
            take_lead(b);
         end else begin
            take_continuation(b);
         end
      end
      if (last) begin
         if (cont_left != EXTRA_NONE) begin
            bad_utf8 = 1'b1;
         end
         if (over_limit) begin
            want = VERDICT_TOO_LARGE;
         end else if (bad_utf8) begin
            want = VERDICT_BAD_UTF8;
         end else if (saw_nul) begin
            want = VERDICT_NUL;
         end else begin
            want = VERDICT_OK;
         end
         expected_verdicts = {expected_verdicts, want};
         clear_text();
      end
   endtask

   // Verdict beats are handled before byte beats of the same edge, since a
   // verdict leaving always belongs to an older text.
   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (reset) begin
         limit_reg = MAX_LENGTH_RESET;
         clear_text();
         expected_verdicts.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = rsp.verdict;
            if (expected_verdicts.size() == 0) begin
               report($sformatf("verdict beat %0d with no text pending", got));
            end else begin
               want = expected_verdicts.pop_front();
               if (got !== want) begin
                  report($sformatf("verdict %0d, expected %0d", got, want));
               end
            end
         end
         if (csr.valid && csr.ready) begin
            limit_reg = csr.data;
         end
         if (req.valid && req.ready) begin
            predict_byte(req.text_byte, req.final_byte);
         end
      end
      verdicts_due <= expected_verdicts.size();
   end

endmodule

[tb/sv/tb.sv]
// Stimulus and verdict for the UTF-8 validator; checking lives in the checker.
module tb;
   import u8v_pkg::*;

   logic clock;
   logic reset;

   u8v_byte_if    req_if ();
   u8v_verdict_if rsp_if ();
   u8v_csr_if     csr_if ();

   int unsigned errors;
   int unsigned awaited;

   int unsigned send_idle_pct = 8;
   int unsigned take_idle_pct = 73;
   int unsigned hold_asks     = 0;
   int unsigned bytes_sent    = 0;

   logic [7:0] text_buf[$];

   text_utf8_validator dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   u8v_verdict_checker verdict_check (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .csr     (csr_if),
      .errors  (errors),
      .awaited (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the whole run.
   initial begin
      #3000000;
      $display("tb: errors");
      $finish;
   end

   // Verdict receiver: random back-pressure, plus a long hold when asked for.
   initial begin
      int unsigned holds_done;
      int unsigned hold_left;
      holds_done = 0;
      hold_left  = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_done != hold_asks) begin
            holds_done++;
            hold_left = 300;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   // Offers one byte beat, after a random number of idle cycles.
   task automatic put_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.text_byte  <= b;
      req_if.final_byte <= last;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++) begin
         put_byte(text_buf[i], i == text_buf.size() - 1);
      end
   endtask

   // Adds one byte at the end of the text being built.
   task automatic append_byte(input logic [7:0] b);
      text_buf = {text_buf, b};
   endtask

   // Directed texts of up to four bytes, first byte in the top of the window.
   task automatic send_packed(input logic [31:0] word, input int n);
      text_buf.delete();
      for (int i = n - 1; i >= 0; i--) begin
         append_byte(word[8*i +: 8]);
      end
      send_text();
   endtask

   // Stops offering until every verdict is in, then lets the block settle.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (awaited != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max(input logic [LENGTH_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   // Appends the code point in the given number of bytes, overlong or not.
   task automatic encode(input logic [20:0] cp, input int n);
      case (n)
         1: append_byte({1'b0, cp[6:0]});
         2: begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
         end
         3: begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
         default: begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
      endcase
   endtask

   // Mostly well-formed characters; the rest is broken in the usual ways.
   task automatic add_symbol();
      int unsigned pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 2) begin
         encode(21'd0, 1);
      end else if (pick < 40) begin
         encode(21'($urandom_range(1, 127)), 1);
      end else if (pick < 58) begin
         encode(21'($urandom_range(128, 2047)), 2);
      end else if (pick < 74) begin
         encode(21'($urandom_range(2048, 65535)), 3);
      end else if (pick < 88) begin
         encode(21'($urandom_range(65536, 1114111)), 4);
      end else begin
         case ($urandom_range(4))
            0: repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(255)));
            1: begin
               // Overlong: a value that would fit in fewer bytes.
               n = $urandom_range(2, 4);
               if (n == 2) begin
                  encode(21'($urandom_range(0, 127)), 2);
               end else if (n == 3) begin
                  encode(21'($urandom_range(0, 2047)), 3);
               end else begin
                  encode(21'($urandom_range(0, 65535)), 4);
               end
            end
            2: encode(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
            3: encode(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
            default: begin
               // Sequence missing its last continuation byte.
               encode(21'($urandom_range(128, 1114111)), $urandom_range(2, 4));
               void'(text_buf.pop_back());
            end
         endcase
      end
   endtask

   task automatic build_text();
      int unsigned chars;
      text_buf.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(255)));
      end else begin
         chars = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
         repeat (chars) add_symbol();
      end
      if (text_buf.size() == 0) begin
         append_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic run_random(input int unsigned budget);
      int unsigned start;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         build_text();
         send_text();
      end
   endtask

   initial begin
      req_if.valid      <= 1'b0;
      req_if.text_byte  <= '0;
      req_if.final_byte <= 1'b0;
      csr_if.valid      <= 1'b0;
      csr_if.data       <= '0;
      reset             <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed texts under the reset length limit.
      send_packed(32'h00, 1);          // embedded NUL
      send_packed(32'h7F, 1);          // largest single byte
      send_packed(32'h80, 1);          // continuation byte as lead
      send_packed(32'hFF, 1);          // lead from F8..FF
      send_packed(32'hC1BF, 2);        // two-byte overlong from lead C1
      send_packed(32'hC2, 1);          // text ends inside a sequence
      send_packed(32'hC241, 2);        // lead without its continuation
      send_packed(32'hE09FBF, 3);      // three-byte overlong
      send_packed(32'hEDA080, 3);      // surrogate
      send_packed(32'hF08FBFBF, 4);    // four-byte overlong
      send_packed(32'hF4908080, 4);    // above the code point range
      send_packed(32'hF48FBFBF, 4);    // largest valid code point
      send_packed(32'hE200, 2);        // NUL breaking a sequence
      wait_idle();

      // Length limit at zero, then exactly at the text length.
      write_max('0);
      send_packed(32'h41, 1);
      send_packed(32'h80, 1);
      wait_idle();
      write_max(32'd3);
      send_packed(32'h414243, 3);
      send_packed(32'h41424344, 4);
      wait_idle();
      write_max(MAX_LENGTH_RESET);

      // Random texts; the receiver holds off for a while in the middle.
      run_random(150);
      hold_asks++;
      run_random(350);
      wait_idle();

      send_idle_pct = 73;
      take_idle_pct = 8;
      write_max(LENGTH_W'($urandom_range(2, 24)));
      run_random(250);
      wait_idle();
      write_max(32'd1);
      run_random(100);
      wait_idle();
      write_max(LENGTH_W'($urandom_range(4, 40)));
      run_random(150);
      wait_idle();

      send_idle_pct = 0;
      take_idle_pct = 0;
      write_max(LENGTH_W'($urandom));
      run_random(150);
      wait_idle();
      write_max(MAX_LENGTH_RESET);
      run_random(350);
      wait_idle();

      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
